// ===== rtl/mbr_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, codes and word types of the msb-first bit reader
package mbr_pkg;

    // reservoir geometry
    localparam int RES_W    = 64;
    localparam int MAX_TAKE = 16;
    localparam int CNT_W    = $clog2(RES_W + 1);
    localparam int EXT_W    = RES_W + MAX_TAKE;

    // fixed field widths
    localparam int CMD_W  = 2;
    localparam int BYTE_W = 8;
    localparam int BC_W   = 7;
    localparam int VAL_W  = 16;
    localparam int ST_W   = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CONSUME = 2'd3;

    // status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_SHORT    = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
    localparam logic [ST_W-1:0] ST_BADCOUNT = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] data_byte;
        logic [BC_W-1:0]   bit_count;
    } item_t;

    typedef struct packed {
        logic [VAL_W-1:0] bits_value;
        logic [BC_W-1:0]  held_bits;
        logic [ST_W-1:0]  status;
    } result_t;

endpackage

// ===== rtl/mbr_in_stage.sv =====
`timescale 1ns / 1ps
// input register stage: captures one command word and holds it until processed
module mbr_in_stage
    import mbr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  item_t in_item,
    input  logic  take,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    // free when empty or when the held word leaves this cycle
    assign in_stall   = valid_reg && !take;
    assign load       = in_valid && !in_stall;
    assign valid_next = load || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/mbr_step.sv =====
`timescale 1ns / 1ps
// one reader step: extract window, new reservoir state and status
module mbr_step
    import mbr_pkg::*;
(
    input  item_t            item,
    input  logic [RES_W-1:0] res,
    input  logic [CNT_W-1:0] vc,
    output logic [RES_W-1:0] res_new,
    output logic [CNT_W-1:0] vc_new,
    output result_t          result
);

    logic [BC_W-1:0]     vc_wide;
    logic [EXT_W-1:0]    ext;
    logic [CNT_W-1:0]    lsh;
    logic [EXT_W-1:0]    aligned;
    logic [MAX_TAKE-1:0] top;
    logic [MAX_TAKE-1:0] window;
    logic [BC_W-1:0]     rsh;
    logic                count_bad;
    logic                short_req;
    logic [CNT_W-1:0]    drop;

    always_comb
    begin
        vc_wide = BC_W'(vc);
        // held bits are the low vc bits; move the first one to the top
        ext     = {res, {MAX_TAKE{1'b0}}};
        lsh     = CNT_W'(RES_W) - vc;
        aligned = ext << lsh;
        top     = aligned[EXT_W-1 -: MAX_TAKE];
        // right-align the asked width, padding zeros come along when short
        rsh     = BC_W'(MAX_TAKE) - item.bit_count;
        window  = top >> rsh;

        count_bad = (item.bit_count == '0) || (item.bit_count > BC_W'(MAX_TAKE));
        short_req = item.bit_count > vc_wide;
        drop      = short_req ? vc : CNT_W'(item.bit_count);

        res_new           = res;
        vc_new            = vc;
        result.bits_value = '0;
        result.status     = ST_OK;

        unique case (item.cmd) inside
            CMD_PUSH:
            begin
                if (vc_wide > BC_W'(RES_W - BYTE_W))
                begin
                    result.status = ST_FULL;
                end
                else
                begin
                    res_new = {res[RES_W-BYTE_W-1:0], item.data_byte};
                    vc_new  = vc + CNT_W'(BYTE_W);
                end
            end
            CMD_GET, CMD_PEEK:
            begin
                if (count_bad)
                begin
                    result.status = ST_BADCOUNT;
                end
                else
                begin
                    result.bits_value = VAL_W'(window);
                    if (short_req)
                    begin
                        result.status = ST_SHORT;
                    end
                    if (item.cmd == CMD_GET)
                    begin
                        vc_new = vc - drop;
                    end
                end
            end
            CMD_CONSUME:
            begin
                vc_new = vc - drop;
                if (short_req)
                begin
                    result.status = ST_SHORT;
                end
            end
            default:
            begin
                vc_new = vc;
            end
        endcase

        result.held_bits = BC_W'(vc_new);
    end

endmodule

// ===== rtl/msb_first_bit_reader_unit.sv =====
`timescale 1ns / 1ps
// top level of the msb-first bit reader: reservoir state and result register
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+---------------------------------
//  in      | input     | in_valid/in_stall  | cmd, data_byte, bit_count
//  out     | output    | out_valid/out_stall| bits_value, held_bits, status
//
// one word per cycle sustained while the result is not stalled; a word is
// captured in the input register, and when the result slot is free the step
// logic updates the reservoir and loads the result register, raising out_valid
// the reservoir feedback loop (shift and count update) sets the clock limit
// reset clears the reservoir, the held count and both valid flags
// a stalled result holds the input register; in_stall rises only then
module msb_first_bit_reader_unit
    import mbr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [BC_W-1:0]   bit_count,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [VAL_W-1:0]  bits_value,
    output logic [BC_W-1:0]   held_bits,
    output logic [ST_W-1:0]   status
);

    item_t            in_item;
    item_t            item;
    logic             item_valid;
    logic             process;

    // reservoir state
    logic [RES_W-1:0] res_reg;
    logic [RES_W-1:0] res_next;
    logic [CNT_W-1:0] vc_reg;
    logic [CNT_W-1:0] vc_next;

    // result register
    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          result_reg;
    result_t          step_result;

    assign in_item = {cmd, data_byte, bit_count};

    // the held word moves on when the result slot is empty or being drained
    assign process = item_valid && (!out_valid_reg || !out_stall);

    mbr_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .take       (process),
        .item_valid (item_valid),
        .item       (item)
    );

    mbr_step u_step
    (
        .item    (item),
        .res     (res_reg),
        .vc      (vc_reg),
        .res_new (res_next),
        .vc_new  (vc_next),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
            vc_reg  <= '0;
        end
        else if (process)
        begin
            res_reg <= res_next;
            vc_reg  <= vc_next;
        end
    end

    // result slot fills on process, empties when taken
    assign out_valid_next = process || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign bits_value = result_reg.bits_value;
    assign held_bits  = result_reg.held_bits;
    assign status     = result_reg.status;

    // held count never exceeds the reservoir
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        BC_W'(vc_reg) <= BC_W'(RES_W))
        else $error("held count beyond reservoir width");

    // a refused byte is reported only with the reservoir near full
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> (held_bits > BC_W'(RES_W - BYTE_W)))
        else $error("full status with room left");

    // a bad count returns no bits
    a_bad_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_BADCOUNT) |-> (bits_value == '0))
        else $error("bits returned on invalid count");

    // state moves only when a word is processed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !process |=> ($stable(vc_reg) && $stable(res_reg)))
        else $error("reservoir changed without a word");

    // a word waiting behind a stalled result stays in the input register
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !process) |=> item_valid)
        else $error("waiting word lost");

endmodule

// ===== tb/sv/bit_reader_checker.sv =====
`timescale 1ns / 1ps
// watches both channels of the msb-first bit reader, predicts each result word and compares
module bit_reader_checker
    import mbr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [BC_W-1:0]   bit_count,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [VAL_W-1:0]  bits_value,
    input  logic [BC_W-1:0]   held_bits,
    input  logic [ST_W-1:0]   status,
    output int                mismatch_count,
    output int                results_owed
);

    localparam int SHOW_LIMIT = 10;

    // predicted reservoir: held bits sit in the low stream_held bits
    logic [RES_W-1:0] stream_bits;
    int               stream_held;
    result_t          owed_q[$];
    int               errs;

    task automatic step_reader(input item_t w, output result_t r);
        int               take;
        int               pad;
        int               count;
        logic [RES_W-1:0] bits;
        logic [RES_W-1:0] aligned;
        r = '0;
        r.status = ST_OK;
        count = int'(w.bit_count);
        case (w.cmd) inside
            CMD_PUSH:
            begin
                if (stream_held > RES_W - BYTE_W)
                    r.status = ST_FULL;
                else
                begin
                    stream_bits = {stream_bits[RES_W-BYTE_W-1:0], w.data_byte};
                    stream_held += BYTE_W;
                end
            end
            CMD_GET, CMD_PEEK:
            begin
                if (count == 0 || count > MAX_TAKE)
                    r.status = ST_BADCOUNT;
                else
                begin
                    take = count;
                    pad = 0;
                    if (take > stream_held)
                    begin
                        pad = take - stream_held;
                        take = stream_held;
                        r.status = ST_SHORT;
                    end
                    if (take > 0)
                    begin
                        bits = (stream_bits >> (stream_held - take)) &
                               ((64'd1 << take) - 64'd1);
                        aligned = bits << pad;
                        r.bits_value = aligned[VAL_W-1:0];
                    end
                    if (w.cmd == CMD_GET)
                        stream_held -= take;
                end
            end
            default:
            begin
                // consume, clamped to what is held
                if (count > stream_held)
                begin
                    stream_held = 0;
                    r.status = ST_SHORT;
                end
                else
                    stream_held -= count;
            end
        endcase
        r.held_bits = stream_held[BC_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        item_t   w;
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            stream_bits = '0;
            stream_held = 0;
            owed_q.delete();
            errs = 0;
            mismatch_count <= 0;
            results_owed <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.bits_value = bits_value;
                got.held_bits = held_bits;
                got.status = status;
                if (owed_q.size() == 0)
                begin
                    errs++;
                    if (errs <= SHOW_LIMIT)
                        $display("%0t: result word with none owed: value %h held %0d status %0d",
                                 $time, got.bits_value, got.held_bits, got.status);
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (got.bits_value !== want.bits_value ||
                        got.held_bits !== want.held_bits ||
                        got.status !== want.status)
                    begin
                        errs++;
                        if (errs <= SHOW_LIMIT)
                            $display("%0t: mismatch exp %h/%0d/%0d got %h/%0d/%0d",
                                     $time, want.bits_value, want.held_bits,
                                     want.status, got.bits_value, got.held_bits,
                                     got.status);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                w.cmd = cmd;
                w.data_byte = data_byte;
                w.bit_count = bit_count;
                step_reader(w, want);
                owed_q.push_back(want);
            end
            mismatch_count <= errs;
            results_owed <= owed_q.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// testbench top of the msb-first bit reader: stimulus, idling, watchdog and verdict
module tb
    import mbr_pkg::*;
();

    // run shape
    localparam int RANDOM_WORDS   = 1625;
    localparam int QUIET_TAIL     = 150;   // last words go with no idling on either side
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no word moving on any channel
    localparam int DRAIN_CYCLES   = 16;    // wait well past the result of the last accept

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [CMD_W-1:0]  cmd = CMD_PUSH;
    logic [BYTE_W-1:0] data_byte = '0;
    logic [BC_W-1:0]   bit_count = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [VAL_W-1:0]  bits_value;
    logic [BC_W-1:0]   held_bits;
    logic [ST_W-1:0]   status;

    int mismatch_count;
    int results_owed;
    int idle_run = 0;
    int cycle_no = 0;
    bit quiet = 1'b0;

    item_t word_q[$];

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    msb_first_bit_reader_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .data_byte  (data_byte),
        .bit_count  (bit_count),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .bits_value (bits_value),
        .held_bits  (held_bits),
        .status     (status)
    );

    bit_reader_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .data_byte      (data_byte),
        .bit_count      (bit_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .bits_value     (bits_value),
        .held_bits      (held_bits),
        .status         (status),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    function automatic item_t make_word(input logic [CMD_W-1:0] c,
                                        input logic [BYTE_W-1:0] b,
                                        input logic [BC_W-1:0] n);
        item_t w;
        w.cmd = c;
        w.data_byte = b;
        w.bit_count = n;
        return w;
    endfunction

    // directed opening: empty reservoir, bad counts, fill to the brim, refusals,
    // short reads with zero padding and clamped consumes
    task automatic load_directed();
        // nothing held: short reads return zero, consume clamps to nothing
        word_q.push_back(make_word(CMD_GET, 8'h00, 7'd8));
        word_q.push_back(make_word(CMD_PEEK, 8'h00, 7'd1));
        word_q.push_back(make_word(CMD_CONSUME, 8'h00, 7'd0));
        word_q.push_back(make_word(CMD_CONSUME, 8'h00, 7'd5));
        // counts outside 1..16 on get and peek
        word_q.push_back(make_word(CMD_GET, 8'h00, 7'd0));
        word_q.push_back(make_word(CMD_PEEK, 8'h00, 7'd17));
        word_q.push_back(make_word(CMD_GET, 8'hFF, 7'd127));
        // fill: the eighth push is accepted at exactly 56 held, the ninth is refused
        word_q.push_back(make_word(CMD_PUSH, 8'hFF, 7'd0));
        word_q.push_back(make_word(CMD_PUSH, 8'h00, 7'd127));
        word_q.push_back(make_word(CMD_PUSH, 8'hA5, 7'd0));
        word_q.push_back(make_word(CMD_PUSH, 8'h5A, 7'd0));
        word_q.push_back(make_word(CMD_PUSH, 8'h81, 7'd0));
        word_q.push_back(make_word(CMD_PUSH, 8'h7E, 7'd0));
        word_q.push_back(make_word(CMD_PUSH, 8'hC3, 7'd0));
        word_q.push_back(make_word(CMD_PUSH, 8'h3C, 7'd0));
        word_q.push_back(make_word(CMD_PUSH, 8'h12, 7'd0));
        // widest peek, single-bit get, then a push at 63 held is still refused
        word_q.push_back(make_word(CMD_PEEK, 8'h00, 7'd16));
        word_q.push_back(make_word(CMD_GET, 8'h00, 7'd1));
        word_q.push_back(make_word(CMD_PUSH, 8'hEE, 7'd0));
        word_q.push_back(make_word(CMD_GET, 8'h00, 7'd16));
        word_q.push_back(make_word(CMD_CONSUME, 8'h00, 7'd3));
        word_q.push_back(make_word(CMD_CONSUME, 8'h00, 7'd127));
        // one byte held, twelve asked: left-aligned with four zeros below
        word_q.push_back(make_word(CMD_PUSH, 8'h9C, 7'd0));
        word_q.push_back(make_word(CMD_GET, 8'h00, 7'd12));
        word_q.push_back(make_word(CMD_CONSUME, 8'h00, 7'd64));
    endtask

    // mostly well-formed traffic; fill_bias swings the level between near empty and full
    function automatic item_t random_word(input bit fill_bias);
        item_t w;
        int    pick;
        w.cmd = CMD_W'($urandom_range(0, 3));
        w.data_byte = BYTE_W'($urandom_range(0, 255));
        w.bit_count = BC_W'($urandom_range(0, 127));
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return w;  // noise: any command with any count
        if (pick < (fill_bias ? 60 : 30))
            w.cmd = CMD_PUSH;
        else if (pick < (fill_bias ? 80 : 65))
        begin
            w.cmd = CMD_GET;
            w.bit_count = BC_W'($urandom_range(1, MAX_TAKE));
        end
        else if (pick < (fill_bias ? 92 : 85))
        begin
            w.cmd = CMD_PEEK;
            w.bit_count = BC_W'($urandom_range(1, MAX_TAKE));
        end
        else
        begin
            w.cmd = CMD_CONSUME;
            w.bit_count = BC_W'($urandom_range(0, 24));
        end
        return w;
    endfunction

    // present one input word and hold it until it is taken
    task automatic send_word(input item_t w, input bit may_idle);
        if (may_idle && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= w.cmd;
        data_byte <= w.data_byte;
        bit_count <= w.bit_count;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // output side stalls in bursts; windows with cycle_no bit 8 set run free
    initial
    begin : stall_gen
        int burst;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (burst > 0)
                burst--;
            else if (!quiet && !cycle_no[8] && $urandom_range(0, 5) == 0)
                burst = $urandom_range(1, 8);
            out_stall <= (burst > 0);
        end
    end

    // watchdog: a run of cycles with no word moving means the block is stuck
    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_run <= 0;
        else if (idle_run >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_run <= idle_run + 1;
    end

    initial
    begin : stimulus
        int total;
        bit fill_bias;
        load_directed();
        fill_bias = 1'b1;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            // bias is drawn anew every 64 words so both full and empty get visited
            if (i % 64 == 0)
                fill_bias = 1'($urandom_range(0, 1));
            word_q.push_back(random_word(fill_bias));
        end
        total = word_q.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < total; i++)
        begin
            if (i >= total - QUIET_TAIL)
                quiet = 1'b1;
            // input gaps only in alternate blocks of 128 words
            send_word(word_q[i], !quiet && ((i / 128) % 2 == 0));
        end
        in_valid <= 1'b0;

        // owed count is registered and reflects the last accept from the following edge
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && results_owed == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
